// File: hw/rtl/hgs_pkg.sv
// shared types and constants of the height grid box smoother
package hgs_pkg;

    localparam int DEF_MAX_SIDE = 64;
    localparam int HEIGHT_W     = 16;
    localparam int SUM_W        = 20;
    localparam int CNT_W        = 4;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic REG_GRID_SIDE  = 1'b0;
    localparam logic REG_PASS_COUNT = 1'b1;

    localparam logic [6:0] GRID_SIDE_RESET  = 7'd17;
    localparam logic [2:0] PASS_COUNT_RESET = 3'd2;

    typedef struct packed {
        logic             in_load;
        logic             st_rd;
        logic             st_wr;
        logic             st_wr_sel;
        logic             sn_rd;
        logic             sn_wr;
        logic             acc_clr;
        logic             acc_add;
        logic             div_start;
        logic [CNT_W-1:0] div_cnt;
        logic             out_load;
        logic [1:0]       out_kind;
        logic             out_rd;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

// File: hw/rtl/height_grid_box_smoother.sv
// top level of the height grid box smoother
// write and read words: accepted, carried out in the dispatch state, then the result register is
//   loaded from the response state once it is free; run word: per pass a copy sweep of the grid
//   into the snapshot, then per cell a read and an add per in-grid neighbor and a 20-step divide
// one word in flight at a time; the single-port grid memory sets the pace of the sweeps
// aresetn synchronous active low: clears control and config (side 17, passes 2), no memory clear
module height_grid_box_smoother #(
    parameter int MAX_SIDE = hgs_pkg::DEF_MAX_SIDE
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [5:0]                   s_row,
    input  logic [5:0]                   s_col,
    input  logic [hgs_pkg::HEIGHT_W-1:0] s_height_in,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_kind,
    output logic [hgs_pkg::HEIGHT_W-1:0] m_height_out,
    // register writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [6:0]                   cfg_data
);
    import hgs_pkg::*;

    // grid address is {row, col}, each one index wide
    localparam int IW = $clog2(MAX_SIDE);
    localparam int AW = 2 * IW;

    cmd_t          cmd;
    sts_t          sts;
    logic [AW-1:0] st_addr;
    logic [AW-1:0] sn_addr;

    // sequencing, sweep counters and config registers
    hgs_ctrl #(
        .MAX_SIDE (MAX_SIDE),
        .IW       (IW),
        .AW       (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_row       (s_row),
        .s_col       (s_col),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .st_addr     (st_addr),
        .sn_addr     (sn_addr)
    );

    // memories, accumulator, divider and result register
    hgs_dp #(
        .AW (AW)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .st_addr      (st_addr),
        .sn_addr      (sn_addr),
        .s_height_in  (s_height_in),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_kind       (m_kind),
        .m_height_out (m_height_out)
    );

endmodule

// File: hw/rtl/hgs_dp.sv
// datapath: grid and snapshot memories, accumulator, divider, result register
module hgs_dp #(
    parameter int AW = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hgs_pkg::cmd_t                cmd,
    output hgs_pkg::sts_t                sts,
    input  logic [AW-1:0]                st_addr,
    input  logic [AW-1:0]                sn_addr,
    input  logic [hgs_pkg::HEIGHT_W-1:0] s_height_in,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [1:0]                   m_kind,
    output logic [hgs_pkg::HEIGHT_W-1:0] m_height_out
);
    import hgs_pkg::*;

    localparam int DEPTH = 1 << AW;
    localparam int DCW   = $clog2(SUM_W + 1);

    logic [HEIGHT_W-1:0] store_mem [0:DEPTH-1];
    logic [HEIGHT_W-1:0] snap_mem  [0:DEPTH-1];
    logic [HEIGHT_W-1:0] st_rdata_reg;
    logic [HEIGHT_W-1:0] sn_rdata_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [HEIGHT_W-1:0] st_wdata;
    logic [SUM_W-1:0]    acc_reg;

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg;
    logic [DCW-1:0]   dcnt_reg, dcnt_next;
    logic             busy_reg, busy_next;
    logic [CNT_W:0]   trial;

    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_kind_reg;
    logic [HEIGHT_W-1:0] m_height_reg;

    assign st_wdata = cmd.st_wr_sel ? quo_reg[HEIGHT_W-1:0] : height_reg;

    always_ff @(posedge aclk) begin
        if (cmd.in_load) height_reg <= s_height_in;
        if (cmd.st_wr) store_mem[st_addr] <= st_wdata;
        if (cmd.st_rd) st_rdata_reg <= store_mem[st_addr];
        if (cmd.sn_wr) snap_mem[sn_addr] <= st_rdata_reg;
        if (cmd.sn_rd) sn_rdata_reg <= snap_mem[sn_addr];
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + SUM_W'(sn_rdata_reg);
        end
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;
        busy_next = busy_reg;
        if (cmd.div_start) begin
            quo_next  = acc_reg;
            rem_next  = '0;
            dcnt_next = DCW'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - 1'b1;
            busy_next = (dcnt_reg != DCW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        if (cmd.div_start) dvs_reg <= cmd.div_cnt;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // result word register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.out_load) begin
            m_kind_reg   <= cmd.out_kind;
            m_height_reg <= cmd.out_rd ? st_rdata_reg : '0;
        end
    end

    assign sts.div_busy  = busy_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_height_out  = m_height_reg;

endmodule

// File: hw/rtl/hgs_ctrl.sv
// controller: item sequencing, grid sweeps and configuration registers
module hgs_ctrl #(
    parameter int MAX_SIDE = hgs_pkg::DEF_MAX_SIDE,
    parameter int IW       = $clog2(MAX_SIDE),
    parameter int AW       = 2 * IW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_operation,
    input  logic [5:0]    s_row,
    input  logic [5:0]    s_col,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [6:0]    cfg_data,
    output hgs_pkg::cmd_t cmd,
    input  hgs_pkg::sts_t sts,
    output logic [AW-1:0] st_addr,
    output logic [AW-1:0] sn_addr
);
    import hgs_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = (SW > 7) ? SW : 7;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_RESP     = 4'd2;
    localparam logic [3:0] S_COPY_RD  = 4'd3;
    localparam logic [3:0] S_COPY_WR  = 4'd4;
    localparam logic [3:0] S_CELL     = 4'd5;
    localparam logic [3:0] S_NB_RD    = 4'd6;
    localparam logic [3:0] S_NB_ACC   = 4'd7;
    localparam logic [3:0] S_DIV_GO   = 4'd8;
    localparam logic [3:0] S_DIV_WAIT = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    op_reg;
    logic [5:0]    row_reg, col_reg;
    logic [6:0]    grid_side_reg;
    logic [2:0]    pass_count_reg;
    logic [2:0]    pass_reg, pass_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;
    logic [IW-1:0] ni_reg, ni_next, nj_reg, nj_next;
    logic [1:0]    kind_reg, kind_next;
    logic          rd_reg, rd_next;

    logic [CW-1:0] side;
    logic          on_grid, last_j, last_i, last_pass;
    logic [IW-1:0] r0, r1, c0, c1;
    logic [1:0]    nr, nc;

    assign side   = (CW'(grid_side_reg) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE)
                                                         : CW'(grid_side_reg);
    assign on_grid = (CW'(row_reg) < side) && (CW'(col_reg) < side);
    assign last_j = (CW'(j_reg) + 1'b1) == side;
    assign last_i = (CW'(i_reg) + 1'b1) == side;
    assign last_pass = ({1'b0, pass_reg} + 1'b1) == {1'b0, pass_count_reg};

    // neighborhood bounds clipped at the grid edges
    assign r0 = (i_reg != '0) ? i_reg - 1'b1 : i_reg;
    assign r1 = ((CW'(i_reg) + 1'b1) < side) ? i_reg + 1'b1 : i_reg;
    assign c0 = (j_reg != '0) ? j_reg - 1'b1 : j_reg;
    assign c1 = ((CW'(j_reg) + 1'b1) < side) ? j_reg + 1'b1 : j_reg;
    assign nr = 2'(r1 - r0) + 2'd1;
    assign nc = 2'(c1 - c0) + 2'd1;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_side_reg  <= GRID_SIDE_RESET;
            pass_count_reg <= PASS_COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRID_SIDE:  grid_side_reg  <= cfg_data;
                REG_PASS_COUNT: pass_count_reg <= cfg_data[2:0];
                default:        ;
            endcase
        end
        if (s_valid && s_ready) begin
            op_reg  <= s_operation;
            row_reg <= s_row;
            col_reg <= s_col;
        end
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ni_next    = ni_reg;
        nj_next    = nj_reg;
        kind_next  = kind_reg;
        rd_next    = rd_reg;
        cmd        = '0;
        st_addr    = {i_reg, j_reg};
        sn_addr    = {i_reg, j_reg};
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                st_addr    = {IW'(row_reg), IW'(col_reg)};
                state_next = S_RESP;
                rd_next    = 1'b0;
                case (op_reg)
                    OP_WRITE: begin
                        cmd.st_wr = on_grid;
                        kind_next = KIND_WRITE;
                    end
                    OP_READ: begin
                        cmd.st_rd = on_grid;
                        rd_next   = on_grid;
                        kind_next = KIND_READ;
                    end
                    OP_RUN: begin
                        kind_next = KIND_DONE;
                        pass_next = '0;
                        i_next    = '0;
                        j_next    = '0;
                        if (pass_count_reg != '0 && side != '0) begin
                            state_next = S_COPY_RD;
                        end
                    end
                    default: kind_next = KIND_WRITE;
                endcase
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = kind_reg;
                    cmd.out_rd   = rd_reg;
                    state_next   = S_IDLE;
                end
            end
            S_COPY_RD: begin
                cmd.st_rd  = 1'b1;
                state_next = S_COPY_WR;
            end
            S_COPY_WR: begin
                cmd.sn_wr  = 1'b1;
                state_next = S_COPY_RD;
                if (last_j) begin
                    j_next = '0;
                    if (last_i) begin
                        i_next     = '0;
                        state_next = S_CELL;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_CELL: begin
                cmd.acc_clr = 1'b1;
                ni_next     = r0;
                nj_next     = c0;
                state_next  = S_NB_RD;
            end
            S_NB_RD: begin
                sn_addr    = {ni_reg, nj_reg};
                cmd.sn_rd  = 1'b1;
                state_next = S_NB_ACC;
            end
            S_NB_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = S_NB_RD;
                if (nj_reg != c1) begin
                    nj_next = nj_reg + 1'b1;
                end else if (ni_reg != r1) begin
                    ni_next = ni_reg + 1'b1;
                    nj_next = c0;
                end else begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_cnt   = CNT_W'(nr) * CNT_W'(nc);
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.st_wr     = 1'b1;
                    cmd.st_wr_sel = 1'b1;
                    state_next    = S_CELL;
                    if (last_j) begin
                        j_next = '0;
                        if (last_i) begin
                            i_next = '0;
                            if (last_pass) begin
                                state_next = S_RESP;
                            end else begin
                                pass_next  = pass_reg + 1'b1;
                                state_next = S_COPY_RD;
                            end
                        end else begin
                            i_next = i_reg + 1'b1;
                        end
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pass_reg <= pass_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        ni_reg   <= ni_next;
        nj_reg   <= nj_next;
        kind_reg <= kind_next;
        rd_reg   <= rd_next;
    end

endmodule

// File: hw/rtl/hgs_checker.sv
// port-level checks of the height grid box smoother, bound to the top level
module hgs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [15:0] m_height_out
);
    import hgs_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_height_out))
        else $error("result word changed while stalled");

    // only read results carry a height
    a_zero_height: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_READ |-> m_height_out == '0)
        else $error("non-read result with nonzero height");

    // one word in flight: input closes after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // result kind is always a defined code
    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind == KIND_WRITE || m_kind == KIND_DONE || m_kind == KIND_READ)
        else $error("undefined result kind");

endmodule

bind height_grid_box_smoother hgs_checker u_hgs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_height_out (m_height_out)
);

// File: dv/testbench.sv
// testbench of the height grid box smoother: queued driver, monitor, grid predictor
`timescale 1ns / 100ps

module testbench;
    import hgs_pkg::*;

    // operation code 3 has no meaning; the block must still answer it
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         GRID_MAX  = DEF_MAX_SIDE;
    localparam int         CELLS     = GRID_MAX * GRID_MAX;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [15:0] height;
    } grid_word_t;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] height;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [5:0]  s_row = '0;
    logic [5:0]  s_col = '0;
    logic [15:0] s_height_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_height_out;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_data = '0;

    height_grid_box_smoother u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_height_in (s_height_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_height_out(m_height_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // predictor state: grid copy, its pass snapshot and which cells hold a written value
    logic [15:0] grid_heights [CELLS];
    logic [15:0] grid_snap [CELLS];
    bit          cell_loaded [CELLS];
    logic [6:0]  side_reg = GRID_SIDE_RESET;
    logic [2:0]  passes_reg = PASS_COUNT_RESET;

    grid_word_t  word_queue [$];      // words waiting for the driver
    answer_t     answer_queue [$];    // answers predicted, not yet seen
    bit          calm = 1'b0;         // no idling on either side
    int          n_words = 0;
    int          n_answers = 0;
    int          n_runs = 0;
    int          n_bad = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // run ends here if the block hangs
    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int live_side();
        return (side_reg > GRID_MAX) ? GRID_MAX : int'(side_reg);
    endfunction

    // one 3x3 mean pass over the live grid, neighbors clipped at the borders
    function automatic void mean_pass(int side);
        int r0, r1, c0, c1, acc, cnt;
        grid_snap = grid_heights;
        for (int r = 0; r < side; r++) begin
            for (int c = 0; c < side; c++) begin
                r0 = (r > 0) ? r - 1 : 0;
                r1 = (r + 1 < side) ? r + 1 : r;
                c0 = (c > 0) ? c - 1 : 0;
                c1 = (c + 1 < side) ? c + 1 : c;
                acc = 0;
                cnt = 0;
                for (int i = r0; i <= r1; i++) begin
                    for (int j = c0; j <= c1; j++) begin
                        acc += grid_snap[i * GRID_MAX + j];
                        cnt++;
                    end
                end
                grid_heights[r * GRID_MAX + c] = 16'(acc / cnt);
            end
        end
    endfunction

    // updates the grid copy for one accepted word and returns its answer
    function automatic answer_t grid_answer(grid_word_t w);
        answer_t a;
        int      side;
        bit      on_grid;
        side    = live_side();
        on_grid = (int'(w.row) < side) && (int'(w.col) < side);
        a.kind   = KIND_WRITE;
        a.height = '0;
        case (w.op)
            OP_WRITE: begin
                if (on_grid) begin
                    grid_heights[w.row * GRID_MAX + w.col] = w.height;
                    cell_loaded[w.row * GRID_MAX + w.col] = 1'b1;
                end
            end
            OP_RUN: begin
                for (int p = 0; p < passes_reg; p++) mean_pass(side);
                a.kind = KIND_DONE;
                n_runs++;
            end
            OP_READ: begin
                a.kind = KIND_READ;
                if (on_grid) a.height = grid_heights[w.row * GRID_MAX + w.col];
            end
            default: ;
        endcase
        return a;
    endfunction

    // driver: holds a word until taken, random gaps only between words
    always @(posedge aclk) begin : word_driver
        int gap_left;
        bit taken;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            taken = s_valid && s_ready;
            if (taken) begin
                answer_queue.insert(answer_queue.size(), grid_answer(word_queue.pop_front()));
                n_words++;
                if (!calm && $urandom_range(3) == 0) gap_left = $urandom_range(1, 17);
            end
            if (!(s_valid && !taken)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (word_queue.size() > 0) begin
                    s_valid     <= 1'b1;
                    s_operation <= word_queue[0].op;
                    s_row       <= word_queue[0].row;
                    s_col       <= word_queue[0].col;
                    s_height_in <= word_queue[0].height;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: short random stalls, plus one long hold so the block backs up
    always @(posedge aclk) begin : answer_sink
        int  hold_left;
        bit  long_done;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
            long_done = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!long_done && n_answers >= 120) begin
                long_done = 1'b1;
                hold_left = 400;
            end else if (!calm && $urandom_range(7) == 0) begin
                hold_left = $urandom_range(1, 17);
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin : answer_check
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            n_answers++;
            if (answer_queue.size() == 0) begin
                $error("result word with nothing predicted: kind %0d height %h",
                       m_kind, m_height_out);
                n_bad++;
            end else begin
                want = answer_queue.pop_front();
                if (m_kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, m_kind);
                    n_bad++;
                end
                if (m_height_out !== want.height) begin
                    $error("height_out: expected %h, actual %h", want.height, m_height_out);
                    n_bad++;
                end
            end
        end
    end

    task automatic push_word(logic [1:0] op, int row, int col, logic [15:0] height);
        grid_word_t w;
        w.op     = op;
        w.row    = 6'(row);
        w.col    = 6'(col);
        w.height = height;
        word_queue.insert(word_queue.size(), w);
    endtask

    // wait until every word is taken and answered, then let the pipe drain
    task automatic drain();
        while (word_queue.size() > 0 || answer_queue.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic reg_write(logic idx, logic [6:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_GRID_SIDE) side_reg = data;
        else passes_reg = data[2:0];
    endtask

    function automatic logic [15:0] pick_height();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // load every live cell not yet written, so runs and reads see only written cells
    task automatic load_grid();
        int side;
        side = live_side();
        for (int r = 0; r < side; r++)
            for (int c = 0; c < side; c++)
                if (!cell_loaded[r * GRID_MAX + c]) begin
                    push_word(OP_WRITE, r, c, pick_height());
                    cell_loaded[r * GRID_MAX + c] = 1'b1;
                end
    endtask

    // random mix: writes anywhere, reads of loaded or off-grid cells, runs, unused ops
    task automatic random_mix(int count, int run_cap);
        int side, sel, r, c, runs;
        side = live_side();
        runs = 0;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            r   = $urandom_range(63);
            c   = $urandom_range(63);
            if (sel < 40) begin
                push_word(OP_WRITE, r, c, pick_height());
                if (r < side && c < side) cell_loaded[r * GRID_MAX + c] = 1'b1;
            end else if (sel < 90 || (sel < 96 && runs >= run_cap)) begin
                if (side > 0 && $urandom_range(3) != 0) begin
                    r = $urandom_range(side - 1);
                    c = $urandom_range(side - 1);
                end
                // a never-written cell on the grid gives way to the corner loaded first
                if (r < side && c < side && !cell_loaded[r * GRID_MAX + c]) begin
                    r = 0;
                    c = 0;
                end
                push_word(OP_READ, r, c, 16'($urandom()));
            end else if (sel < 96) begin
                push_word(OP_RUN, r, c, 16'($urandom()));
                runs++;
            end else begin
                push_word(OP_UNUSED, r, c, 16'($urandom()));
            end
        end
    endtask

    task automatic phase(logic [6:0] side, logic [2:0] passes, int count, int run_cap,
                         bit fill);
        drain();
        reg_write(REG_GRID_SIDE, side);
        reg_write(REG_PASS_COUNT, passes);
        if (fill) load_grid();
        random_mix(count, run_cap);
    endtask

    initial begin : main_flow
        for (int i = 0; i < CELLS; i++) begin
            grid_heights[i] = '0;
            cell_loaded[i]  = 1'b0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: 3x3 grid, one pass; corners, edges, center, off-grid and unused op
        reg_write(REG_GRID_SIDE, 7'd3);
        reg_write(REG_PASS_COUNT, 3'd1);
        push_word(OP_WRITE, 0, 0, 16'hFFFF);
        push_word(OP_WRITE, 0, 1, 16'h0000);
        push_word(OP_WRITE, 0, 2, 16'hFFFF);
        push_word(OP_WRITE, 1, 0, 16'h1234);
        push_word(OP_WRITE, 1, 1, 16'hFFFF);
        push_word(OP_WRITE, 1, 2, 16'h0001);
        push_word(OP_WRITE, 2, 0, 16'hFFFF);
        push_word(OP_WRITE, 2, 1, 16'h8000);
        push_word(OP_WRITE, 2, 2, 16'hFFFF);
        for (int i = 0; i < 9; i++) cell_loaded[(i / 3) * GRID_MAX + i % 3] = 1'b1;
        push_word(OP_READ, 2, 2, 16'h0000);
        push_word(OP_WRITE, 3, 0, 16'hABCD);      // just off the grid: ignored
        push_word(OP_WRITE, 63, 63, 16'hFFFF);
        push_word(OP_READ, 63, 63, 16'hFFFF);     // off the grid: zero
        push_word(OP_READ, 0, 3, 16'h0000);
        push_word(OP_UNUSED, 63, 63, 16'hFFFF);
        push_word(OP_RUN, 0, 0, 16'h0000);
        push_word(OP_READ, 0, 0, 16'h0000);       // corner, 4 neighbors
        push_word(OP_READ, 0, 1, 16'h0000);       // edge, 6 neighbors
        push_word(OP_READ, 1, 1, 16'h0000);       // center, 9 neighbors
        push_word(OP_RUN, 63, 63, 16'hFFFF);
        push_word(OP_READ, 2, 1, 16'h0000);

        // random phases across sides and pass counts, extremes included
        phase(7'd1,   3'd7, 40, 100, 1'b1);
        phase(7'd2,   3'd3, 40, 100, 1'b1);
        phase(7'd10,  3'd2, 40, 3, 1'b1);
        phase(7'd5,   3'd0, 40, 100, 1'b1);
        phase(7'd12,  3'd4, 40, 3, 1'b1);
        phase(7'd64,  3'd1, 40, 0, 1'b0);         // full size: writes, reads and unused ops, no runs
        phase(7'd127, 3'd0, 40, 100, 1'b0);       // side above the maximum saturates
        phase(7'd0,   3'd7, 40, 100, 1'b0);       // empty grid
        drain();
        calm = 1'b1;
        phase(7'd8,   3'd7, 40, 3, 1'b1);

        drain();
        $display("covered %0d words, %0d result words, %0d smoothing runs", n_words,
                 n_answers, n_runs);
        $display("grid sides 0 to 127, pass counts 0 to 7, off-grid and unused-op words");
        if (n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
